>>> sv/efpc_pkg.sv
// Shared types, constants and the CRC byte function for the frame parser.
// Used by the top level, front end and back end of the frame parser CRC-32 check core; no dependencies.
package efpc_pkg;

    localparam logic [31:0] CRC_32_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_32C_POLY  = 32'h82F63B78;
    localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
    localparam logic [15:0] TRAILER_BYTES = 16'd4;

    localparam int CMD_DEPTH_DEF = 4;
    localparam int RES_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        PH_RESULT  = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_TEXT    = 3'd3,
        PH_TRAILER = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_CRC   = 3'd1,
        OP_TEXT  = 3'd2,
        OP_TRAIL = 3'd3,
        OP_LAST  = 3'd4
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] text_byte;
        logic       result_flag;
        logic       crc_match;
        logic       frame_end;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                             input logic [7:0]  data,
                                             input logic [31:0] poly);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> sv/error_frame_parser_crc32_check_core.sv
// Top level of the length-prefixed frame parser with CRC-32 check.
// Depends on efpc_pkg, efpc_fifo, efpc_front and efpc_back.
//
// Takes one frame byte per clock while full is low, and delivers up to one result per
// clock. The front end classifies each byte by frame position in the cycle it
// is pushed; the back end updates the CRC with an unrolled eight-bit step, and
// each byte passes through the command queue and its result through the result
// queue before it reaches the output ports. Command and result
// queues let either side stall on its own; full rises only when the command
// queue fills behind a stalled output.
module error_frame_parser_crc32_check_core #(
    parameter int CMD_DEPTH = efpc_pkg::CMD_DEPTH_DEF,
    parameter int RES_DEPTH = efpc_pkg::RES_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        push,
    input  logic [7:0]  i_frame_byte,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output logic        o_item_kind,
    output logic [7:0]  o_text_byte,
    output logic        o_result_flag,
    output logic        o_crc_match,
    output logic        o_frame_end
);

    efpc_pkg::t_cmd    front_cmd;
    efpc_pkg::t_cmd    back_cmd;
    efpc_pkg::t_result res;
    logic              accept;
    logic              cmd_empty;
    logic              cmd_pop;

    assign accept = push & ~full;

    efpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_byte  (i_frame_byte),
        .o_cmd   (front_cmd)
    );

    efpc_fifo #(
        .T     (efpc_pkg::t_cmd),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    efpc_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (back_cmd),
        .i_cmd_empty   (cmd_empty),
        .o_cmd_pop     (cmd_pop),
        .i_pop         (pop),
        .o_res         (res),
        .o_empty       (empty)
    );

    assign o_item_kind   = res.item_kind;
    assign o_text_byte   = res.text_byte;
    assign o_result_flag = res.result_flag;
    assign o_crc_match   = res.crc_match;
    assign o_frame_end   = res.frame_end;

endmodule

>>> sv/efpc_fifo.sv
// Small first-in first-out queue of a generic payload type.
// Used for the command queue and the result queue; no package dependencies.
module efpc_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> sv/efpc_front.sv
// Front end: tracks the frame layout and turns each byte into a command.
// Depends on efpc_pkg for the phase and command types.
module efpc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    output efpc_pkg::t_cmd o_cmd
);

    efpc_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_bytes_left, n_bytes_left;
    logic [7:0]       r_len_high, n_len_high;
    logic [15:0]      len;
    logic [15:0]      dec;

    assign len = {r_len_high, i_byte};
    assign dec = r_bytes_left - 16'd1;

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_len_high   = r_len_high;
        o_cmd.data   = i_byte;
        o_cmd.op     = efpc_pkg::OP_START;
        case (r_phase)
            efpc_pkg::PH_LEN_HI: begin
                o_cmd.op   = efpc_pkg::OP_CRC;
                n_len_high = i_byte;
                n_phase    = efpc_pkg::PH_LEN_LO;
            end
            efpc_pkg::PH_LEN_LO: begin
                o_cmd.op = efpc_pkg::OP_CRC;
                if (len == 16'd0) begin
                    n_bytes_left = efpc_pkg::TRAILER_BYTES;
                    n_phase      = efpc_pkg::PH_TRAILER;
                end else begin
                    n_bytes_left = len;
                    n_phase      = efpc_pkg::PH_TEXT;
                end
            end
            efpc_pkg::PH_TEXT: begin
                o_cmd.op = efpc_pkg::OP_TEXT;
                if (dec == 16'd0) begin
                    n_bytes_left = efpc_pkg::TRAILER_BYTES;
                    n_phase      = efpc_pkg::PH_TRAILER;
                end else begin
                    n_bytes_left = dec;
                end
            end
            efpc_pkg::PH_TRAILER: begin
                n_bytes_left = dec;
                if (dec == 16'd0) begin
                    o_cmd.op = efpc_pkg::OP_LAST;
                    n_phase  = efpc_pkg::PH_RESULT;
                end else begin
                    o_cmd.op = efpc_pkg::OP_TRAIL;
                end
            end
            default: begin
                o_cmd.op     = efpc_pkg::OP_START;
                n_bytes_left = 16'd0;
                n_phase      = efpc_pkg::PH_LEN_HI;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= efpc_pkg::PH_RESULT;
            r_bytes_left <= '0;
            r_len_high   <= '0;
        end else if (i_valid) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_len_high   <= n_len_high;
        end
    end

endmodule

>>> sv/efpc_back.sv
// Back end: runs the CRC, collects the trailer and queues result items.
// Depends on efpc_pkg and efpc_fifo for the result queue.
module efpc_back #(
    parameter int RES_DEPTH = efpc_pkg::RES_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [31:0]    i_cfg_wr_data,
    input  efpc_pkg::t_cmd i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output efpc_pkg::t_result o_res,
    output logic           o_empty
);

    logic [31:0]       r_poly;
    logic [31:0]       r_crc, n_crc;
    logic [31:0]       r_rcv, n_rcv;
    logic              r_saved, n_saved;
    logic [31:0]       crc_next;
    logic [31:0]       rcv_shift;
    logic              res_full;
    logic              res_push;
    efpc_pkg::t_result res;

    assign o_cmd_pop = ~i_cmd_empty & ~res_full;
    assign crc_next  = efpc_pkg::crc_byte(r_crc, i_cmd.data, r_poly);
    assign rcv_shift = {r_rcv[23:0], i_cmd.data};

    always_comb begin
        n_crc    = r_crc;
        n_rcv    = r_rcv;
        n_saved  = r_saved;
        res_push = 1'b0;
        res      = '0;
        case (i_cmd.op)
            efpc_pkg::OP_START: begin
                n_crc   = efpc_pkg::crc_byte(efpc_pkg::CRC_INIT, i_cmd.data, r_poly);
                n_saved = i_cmd.data[0];
                n_rcv   = '0;
            end
            efpc_pkg::OP_CRC: begin
                n_crc = crc_next;
            end
            efpc_pkg::OP_TEXT: begin
                n_crc         = crc_next;
                res_push      = 1'b1;
                res.text_byte = i_cmd.data;
            end
            efpc_pkg::OP_TRAIL: begin
                n_rcv = rcv_shift;
            end
            efpc_pkg::OP_LAST: begin
                n_rcv           = rcv_shift;
                n_crc           = efpc_pkg::CRC_INIT;
                res_push        = 1'b1;
                res.item_kind   = 1'b1;
                res.result_flag = r_saved;
                res.crc_match   = (rcv_shift == ~r_crc);
                res.frame_end   = 1'b1;
            end
            default: begin
                n_crc = r_crc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= efpc_pkg::CRC_32_POLY;
        end else if (i_cfg_wr_en) begin
            r_poly <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= efpc_pkg::CRC_INIT;
            r_rcv   <= '0;
            r_saved <= 1'b0;
        end else if (o_cmd_pop) begin
            r_crc   <= n_crc;
            r_rcv   <= n_rcv;
            r_saved <= n_saved;
        end
    end

    efpc_fifo #(
        .T     (efpc_pkg::t_result),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_cmd_pop & res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_res),
        .o_empty (o_empty)
    );

endmodule

>>> verif/error_frame_parser_crc32_check_core_test.sv
`timescale 1ns / 1ps
// Testbench for error_frame_parser_crc32_check_core: directed frames, then random frames
// under changing CRC polynomials, checked against a built-in frame parser. Needs efpc_pkg.
module error_frame_parser_crc32_check_core_test;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int SETTLE_CYCLES = 16;
    localparam int RUN_LIMIT     = 200000;

    typedef enum logic [1:0] {
        ROW_BYTE = 2'd0,
        ROW_CRC  = 2'd1,
        ROW_SYNC = 2'd2,
        ROW_POLY = 2'd3
    } t_row_kind;

    typedef enum logic [2:0] {
        TAIL_GOOD = 3'd0,
        TAIL_FLIP = 3'd1,
        TAIL_RAW  = 3'd2,
        TAIL_CUT  = 3'd3,
        TAIL_OPEN = 3'd4
    } t_tail;

    typedef struct packed {
        t_row_kind         kind;
        logic [31:0]       val;
        logic              typed;
        efpc_pkg::t_result res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = 32'h0;
    logic        push          = 1'b0;
    logic [7:0]  i_frame_byte  = 8'h0;
    logic        pop           = 1'b0;
    logic        full;
    logic        empty;
    logic        o_item_kind;
    logic [7:0]  o_text_byte;
    logic        o_result_flag;
    logic        o_crc_match;
    logic        o_frame_end;

    error_frame_parser_crc32_check_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .i_frame_byte  (i_frame_byte),
        .full          (full),
        .pop           (pop),
        .empty         (empty),
        .o_item_kind   (o_item_kind),
        .o_text_byte   (o_text_byte),
        .o_result_flag (o_result_flag),
        .o_crc_match   (o_crc_match),
        .o_frame_end   (o_frame_end)
    );

    // frame parser state
    efpc_pkg::t_phase fp_phase  = efpc_pkg::PH_RESULT;
    logic [15:0]      fp_left   = 16'h0;
    logic [31:0]      fp_crc    = efpc_pkg::CRC_INIT;
    logic [31:0]      fp_rx     = 32'h0;
    logic             fp_flag   = 1'b0;
    logic [7:0]       fp_len_hi = 8'h0;
    logic [31:0]      fp_poly   = efpc_pkg::CRC_32_POLY;

    t_row              byte_plan[$];
    t_row              table_rows[$];
    efpc_pkg::t_result parsed_q[$];
    t_row              cur_row;

    bit feed_idle = 1'b1;
    bit sink_idle = 1'b1;
    int gap_left   = 0;
    int stall_left = 0;
    int mismatches = 0;
    int items_out  = 0;
    int bytes_in   = 0;
    int frames_planned = 0;
    int poly_writes    = 0;
    int cycle_count    = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        logic        lsb;
        v = c ^ {24'h0, b};
        repeat (8) begin
            lsb = v[0];
            v = v >> 1;
            if (lsb) begin
                v = v ^ fp_poly;
            end
        end
        return v;
    endfunction

    task automatic parse_byte(input logic [7:0] b, output bit got,
                              output efpc_pkg::t_result r);
        got = 1'b0;
        r = '0;
        case (fp_phase)
            efpc_pkg::PH_LEN_HI: begin
                fp_crc = crc_fold(fp_crc, b);
                fp_len_hi = b;
                fp_phase = efpc_pkg::PH_LEN_LO;
            end
            efpc_pkg::PH_LEN_LO: begin
                fp_crc = crc_fold(fp_crc, b);
                fp_left = {fp_len_hi, b};
                fp_rx = 32'h0;
                if (fp_left == 16'h0) begin
                    fp_left = efpc_pkg::TRAILER_BYTES;
                    fp_phase = efpc_pkg::PH_TRAILER;
                end else begin
                    fp_phase = efpc_pkg::PH_TEXT;
                end
            end
            efpc_pkg::PH_TEXT: begin
                fp_crc = crc_fold(fp_crc, b);
                fp_left = fp_left - 16'h1;
                if (fp_left == 16'h0) begin
                    fp_left = efpc_pkg::TRAILER_BYTES;
                    fp_phase = efpc_pkg::PH_TRAILER;
                end
                got = 1'b1;
                r.text_byte = b;
            end
            efpc_pkg::PH_TRAILER: begin
                fp_rx = {fp_rx[23:0], b};
                fp_left = fp_left - 16'h1;
                if (fp_left == 16'h0) begin
                    got = 1'b1;
                    r.item_kind = 1'b1;
                    r.result_flag = fp_flag;
                    r.crc_match = (fp_rx == ~fp_crc);
                    r.frame_end = 1'b1;
                    fp_phase = efpc_pkg::PH_RESULT;
                    fp_crc = efpc_pkg::CRC_INIT;
                end
            end
            default: begin
                fp_crc = crc_fold(efpc_pkg::CRC_INIT, b);
                fp_flag = b[0];
                fp_rx = 32'h0;
                fp_left = 16'h0;
                fp_phase = efpc_pkg::PH_LEN_HI;
            end
        endcase
    endtask

    function automatic logic [7:0] trailer_byte();
        logic [31:0] t;
        t = ~fp_crc;
        return 8'(t >> (8 * (fp_left - 16'h1)));
    endfunction

    function automatic t_row row(input t_row_kind k, input logic [31:0] v);
        t_row e;
        e = '0;
        e.kind = k;
        e.val = v;
        return e;
    endfunction

    function automatic t_row text_row(input logic [7:0] b);
        t_row e;
        e = row(ROW_BYTE, {24'h0, b});
        e.typed = 1'b1;
        e.res.text_byte = b;
        return e;
    endfunction

    function automatic t_row status_row(input logic [7:0] mask, input logic flag,
                                        input logic match);
        t_row e;
        e = row(ROW_CRC, {24'h0, mask});
        e.typed = 1'b1;
        e.res.item_kind = 1'b1;
        e.res.result_flag = flag;
        e.res.crc_match = match;
        e.res.frame_end = 1'b1;
        return e;
    endfunction

    function automatic int plan_frame(input int len, input int keep, input t_tail tail);
        int n;
        int hit;
        n = 3;
        hit = $urandom_range(0, 3);
        frames_planned++;
        byte_plan.push_back(row(ROW_BYTE, $urandom_range(0, 255)));
        byte_plan.push_back(row(ROW_BYTE, (len >> 8) & 255));
        byte_plan.push_back(row(ROW_BYTE, len & 255));
        for (int k = 0; k < keep; k++) begin
            byte_plan.push_back(row(ROW_BYTE, $urandom_range(0, 255)));
            n++;
        end
        case (tail)
            TAIL_GOOD: begin
                repeat (4) byte_plan.push_back(row(ROW_CRC, 32'h0));
                n += 4;
            end
            TAIL_FLIP: begin
                for (int j = 0; j < 4; j++) begin
                    byte_plan.push_back(row(ROW_CRC, (j == hit) ? (1 << $urandom_range(0, 7)) : 0));
                end
                n += 4;
            end
            TAIL_RAW: begin
                repeat (4) byte_plan.push_back(row(ROW_BYTE, $urandom_range(0, 255)));
                n += 4;
            end
            TAIL_CUT: begin
                byte_plan.push_back(row(ROW_SYNC, 32'h0));
            end
            default: begin
            end
        endcase
        return n;
    endfunction

    task automatic pick_next(output bit have, output logic [7:0] nb);
        t_row e;
        have = 1'b0;
        nb = 8'h0;
        while (!have && byte_plan.size() > 0) begin
            e = byte_plan[0];
            case (e.kind)
                ROW_SYNC: begin
                    if (fp_phase == efpc_pkg::PH_RESULT) begin
                        byte_plan.delete(0);
                    end else begin
                        have = 1'b1;
                        if (fp_phase == efpc_pkg::PH_TRAILER) begin
                            nb = trailer_byte();
                        end else if (fp_phase == efpc_pkg::PH_LEN_HI) begin
                            nb = 8'h0;
                        end else begin
                            nb = 8'($urandom_range(0, 255));
                        end
                        cur_row = row(ROW_BYTE, {24'h0, nb});
                    end
                end
                ROW_CRC: begin
                    have = 1'b1;
                    nb = (fp_phase == efpc_pkg::PH_TRAILER) ? (trailer_byte() ^ e.val[7:0])
                                                             : e.val[7:0];
                    cur_row = e;
                    byte_plan.delete(0);
                end
                default: begin
                    have = 1'b1;
                    nb = e.val[7:0];
                    cur_row = e;
                    byte_plan.delete(0);
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : feed
        bit                have;
        bit                got;
        logic [7:0]        nb;
        efpc_pkg::t_result r;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (push) begin
                parse_byte(i_frame_byte, got, r);
                bytes_in++;
                if (cur_row.typed) begin
                    parsed_q.push_back(cur_row.res);
                end else if (got) begin
                    parsed_q.push_back(r);
                end
            end
            have = 1'b0;
            nb = 8'h0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (feed_idle && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 11) - 1;
            end else begin
                pick_next(have, nb);
            end
            push <= have;
            if (have) begin
                i_frame_byte <= nb;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : sink
        efpc_pkg::t_result w;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                items_out++;
                if (parsed_q.size() == 0) begin
                    $error("output item with nothing pending: kind %0h text %0h",
                           o_item_kind, o_text_byte);
                    mismatches++;
                end else begin
                    w = parsed_q.pop_front();
                    check_field("item_kind", w.item_kind, o_item_kind);
                    check_field("text_byte", w.text_byte, o_text_byte);
                    check_field("result_flag", w.result_flag, o_result_flag);
                    check_field("crc_match", w.crc_match, o_crc_match);
                    check_field("frame_end", w.frame_end, o_frame_end);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic drain_all();
        while (byte_plan.size() != 0 || push || parsed_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_poly(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        fp_poly = v;
        poly_writes++;
    endtask

    initial begin : run
        int planned;
        int goal;
        int n;
        int len;
        int keep;
        int sel;
        t_tail tail;
        logic [31:0] poly;

        // empty text, flag set, good trailer
        table_rows.push_back(row(ROW_BYTE, 32'hFF));
        table_rows.push_back(row(ROW_BYTE, 32'h00));
        table_rows.push_back(row(ROW_BYTE, 32'h00));
        repeat (3) table_rows.push_back(row(ROW_CRC, 32'h0));
        table_rows.push_back(status_row(8'h00, 1'b1, 1'b1));
        // two text bytes at the extremes, corrupted trailer
        table_rows.push_back(row(ROW_BYTE, 32'h00));
        table_rows.push_back(row(ROW_BYTE, 32'h00));
        table_rows.push_back(row(ROW_BYTE, 32'h02));
        table_rows.push_back(text_row(8'h00));
        table_rows.push_back(text_row(8'hFF));
        repeat (3) table_rows.push_back(row(ROW_CRC, 32'h0));
        table_rows.push_back(status_row(8'h80, 1'b0, 1'b0));
        // polynomial changes before and inside a frame
        table_rows.push_back(row(ROW_POLY, efpc_pkg::CRC_32C_POLY));
        table_rows.push_back(row(ROW_BYTE, 32'h02));
        table_rows.push_back(row(ROW_BYTE, 32'h00));
        table_rows.push_back(row(ROW_BYTE, 32'h01));
        table_rows.push_back(row(ROW_POLY, 32'hFFFFFFFF));
        table_rows.push_back(text_row(8'h5A));
        table_rows.push_back(row(ROW_POLY, 32'h00000000));
        repeat (3) table_rows.push_back(row(ROW_CRC, 32'h0));
        table_rows.push_back(status_row(8'h00, 1'b0, 1'b1));
        frames_planned = 3;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) begin
            if (table_rows[i].kind == ROW_POLY) begin
                drain_all();
                write_poly(table_rows[i].val);
            end else begin
                byte_plan.push_back(table_rows[i]);
            end
        end
        drain_all();

        planned = 0;
        while (planned < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: poly = efpc_pkg::CRC_32_POLY;
                1: poly = efpc_pkg::CRC_32C_POLY;
                2: poly = 32'h00000000;
                3: poly = 32'hFFFFFFFF;
                default: poly = $urandom();
            endcase
            write_poly(poly);
            feed_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            byte_plan.push_back(row(ROW_SYNC, 32'h0));
            goal = $urandom_range(60, 200);
            n = 0;
            while (n < goal) begin
                sel = $urandom_range(0, 99);
                if (sel < 65) begin
                    len = $urandom_range(0, 8);
                end else if (sel < 90) begin
                    len = $urandom_range(9, 40);
                end else begin
                    len = $urandom_range(41, 300);
                end
                keep = len;
                sel = $urandom_range(0, 99);
                if (sel < 78) begin
                    tail = TAIL_GOOD;
                end else if (sel < 88) begin
                    tail = TAIL_FLIP;
                end else if (sel < 94) begin
                    tail = TAIL_RAW;
                end else begin
                    tail = TAIL_CUT;
                    keep = (len == 0) ? 0 : $urandom_range(0, len - 1);
                end
                n += plan_frame(len, keep, tail);
            end
            // leave a frame open across the next polynomial write
            if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, 20);
                n += plan_frame(len, $urandom_range(0, len - 1), TAIL_OPEN);
            end
            planned += n;
            drain_all();
        end

        write_poly(efpc_pkg::CRC_32_POLY);
        feed_idle = 1'b0;
        sink_idle = 1'b0;
        byte_plan.push_back(row(ROW_SYNC, 32'h0));
        void'(plan_frame(256, 256, TAIL_GOOD));
        void'(plan_frame(0, 0, TAIL_GOOD));
        void'(plan_frame(1, 1, TAIL_FLIP));
        drain_all();

        $display("Covered %0d frames, %0d bytes in, %0d polynomial writes.",
                 frames_planned, bytes_in, poly_writes);
        $display("Compared %0d output items, %0d mismatches.", items_out, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
